[design/mspm_pkg.sv]
// Shared constants, codes and types for the min-position merge block.
`timescale 1ns / 1ps

package mspm_pkg;

	localparam int MAX_STREAMS = 16;
	localparam int SLOT_W      = $clog2(MAX_STREAMS);
	localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
	localparam int POS_W       = 32;
	localparam int STRM_CNT_W  = 5;
	localparam int EFF_W       = (CNT_W > STRM_CNT_W) ? CNT_W : STRM_CNT_W;
	localparam int DONE_W      = 5;
	localparam int IN_SLOT_W   = 4;
	localparam int OUT_SLOT_W  = 4;
	localparam int REQ_W       = 2;
	localparam int STATUS_W    = 2;

	localparam logic [REQ_W-1:0] REQ_ARRIVE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_NEXT    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

	localparam logic [STATUS_W-1:0] ST_SELECTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

	// running minimum passed down the cell chain
	typedef struct packed {
		logic                    found;
		logic [SLOT_W-1:0]       idx;
		logic signed [POS_W-1:0] key;
	} token_t;

	// broadcast command to every cell
	typedef struct packed {
		logic                    arrive;
		logic                    clear;
		logic                    pick;
		logic [SLOT_W-1:0]       slot;
		logic signed [POS_W-1:0] pos;
		logic                    exhausted;
		logic [EFF_W-1:0]        count;
	} cell_cmd_t;

endpackage

[design/mspm_cell.sv]
// One slot cell: holds a stream's head record and folds it into the running minimum.
`timescale 1ns / 1ps

module mspm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mspm_pkg::SLOT_W-1:0]   my_idx,
	input  mspm_pkg::cell_cmd_t           cmd,
	input  mspm_pkg::token_t              tok_in,
	output mspm_pkg::token_t              tok_out,
	output logic                          done_inc
);
	import mspm_pkg::*;

	logic                    held_q;
	logic                    fin_q;
	logic signed [POS_W-1:0] key_q;
	logic                    found_q;
	logic [SLOT_W-1:0]       idx_q;
	logic signed [POS_W-1:0] best_q;

	logic active;
	logic match;
	logic fill_ok;
	logic take;

	assign active   = EFF_W'(my_idx) < cmd.count;
	assign match    = (cmd.slot == my_idx);
	assign fill_ok  = cmd.arrive && match && active && !held_q && !fin_q;
	assign done_inc = fill_ok && cmd.exhausted;
	// strict compare: an earlier cell wins a tie
	assign take     = active && held_q && (!tok_in.found || (key_q < tok_in.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			fin_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			found_q <= take || tok_in.found;
			if (cmd.clear) begin
				held_q <= 1'b0;
				fin_q  <= 1'b0;
			end else if (fill_ok) begin
				if (cmd.exhausted)
					fin_q <= 1'b1;
				else
					held_q <= 1'b1;
			end else if (cmd.pick && match) begin
				held_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_ok && !cmd.exhausted)
			key_q <= cmd.pos;
		idx_q  <= take ? my_idx : tok_in.idx;
		best_q <= take ? key_q : tok_in.key;
	end

	assign tok_out = '{found: found_q, idx: idx_q, key: best_q};

endmodule

[design/multi_stream_min_position_merge.sv]
// Top level of the k-way merge by position: request handling, done count and result register.
`timescale 1ns / 1ps

// Merges up to MAX_STREAMS sorted record streams by position. Each stream
// owns one cell of a chain; a cell holds at most one head record. Requests
// arrive on the s_ side with the kind in s_tuser: an arrival fills an empty
// active slot (or marks it finished when the stream has run dry), a next
// request returns the held record with the least position (lowest slot wins
// ties) and frees that slot, and a restart empties every slot. Only next
// requests produce a response on the m_ side. Arrivals, restarts and next
// requests that find every active stream finished complete without a search.
// A next request that must search walks a running minimum down the cell
// chain, one cell per cycle, and the response is loaded once the minimum has
// passed the last cell and the output register is free. The response sits in
// an output register, and a new request is taken while it waits as long as
// the register is free to be rewritten in the same cycle. stream_count is to
// be written through cfg_we/cfg_wdata only while idle; this is not enforced.
module multi_stream_min_position_merge (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // stream_count
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // [3:0] stream_slot, [35:4] record_position,
	                                 // [36] stream_exhausted, [39:37] zero
	input  logic [1:0]  s_tuser,     // req_type
	// response side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // [3:0] selected_slot, [35:4] selected_position,
	                                 // [39:36] zero
	output logic [1:0]  m_tuser      // status
);
	import mspm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;

	// request fields
	logic [IN_SLOT_W-1:0]    in_slot;
	logic signed [POS_W-1:0] in_pos;
	logic                    in_exh;
	logic [REQ_W-1:0]        in_req;

	assign in_slot = s_tdata[3:0];
	assign in_pos  = s_tdata[35:4];
	assign in_exh  = s_tdata[36];
	assign in_req  = s_tuser;

	logic [STRM_CNT_W-1:0] stream_count_q;
	logic [DONE_W-1:0]     done_q;
	logic [1:0]            state_q;
	logic [CNT_W-1:0]      scan_cnt_q;

	logic                    m_valid_q;
	logic [STATUS_W-1:0]     m_status_q;
	logic [OUT_SLOT_W-1:0]   m_slot_q;
	logic signed [POS_W-1:0] m_pos_q;

	// effective count: values above MAX_STREAMS act as MAX_STREAMS
	logic [EFF_W-1:0] count_eff;
	logic [EFF_W-1:0] cfg_ext;
	assign cfg_ext   = EFF_W'(stream_count_q);
	assign count_eff = (cfg_ext > EFF_W'(MAX_STREAMS)) ? EFF_W'(MAX_STREAMS) : cfg_ext;

	logic out_free;
	logic s_acc;
	logic slot_ok;
	logic all_done;
	logic scan_done;
	logic any_done_inc;

	token_t                 tok   [MAX_STREAMS];
	token_t                 tin   [MAX_STREAMS];
	logic [MAX_STREAMS-1:0] done_inc;
	cell_cmd_t              cmd;
	token_t                 last_tok;

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign s_acc     = s_tvalid && s_tready;
	assign slot_ok   = EFF_W'(in_slot) < count_eff;
	assign all_done  = (EFF_W'(done_q) == count_eff);
	assign last_tok  = tok[MAX_STREAMS-1];
	// last cell's register is settled once the minimum has crossed every cell
	assign scan_done = (state_q == S_SCAN) && (scan_cnt_q == CNT_W'(MAX_STREAMS)) && out_free;
	assign any_done_inc = |done_inc;

	always_comb begin
		cmd.arrive    = s_acc && (in_req == REQ_ARRIVE) && slot_ok;
		cmd.clear     = s_acc && (in_req == REQ_RESTART);
		cmd.pick      = scan_done && last_tok.found;
		cmd.slot      = cmd.pick ? last_tok.idx : SLOT_W'(in_slot);
		cmd.pos       = in_pos;
		cmd.exhausted = in_exh;
		cmd.count     = count_eff;
	end

	// cell chain: the seed at the head carries no record
	genvar gi;
	generate
		for (gi = 0; gi < MAX_STREAMS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign tin[gi] = '{found: 1'b0, idx: '0, key: '0};
			end else begin : g_link
				assign tin[gi] = tok[gi-1];
			end
			mspm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.my_idx   (SLOT_W'(gi)),
				.cmd      (cmd),
				.tok_in   (tin[gi]),
				.tok_out  (tok[gi]),
				.done_inc (done_inc[gi])
			);
		end
	endgenerate

	// control: config, done count, sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q <= STRM_CNT_W'(16);
			done_q         <= '0;
			state_q        <= S_IDLE;
			scan_cnt_q     <= '0;
		end else begin
			if (cfg_we)
				stream_count_q <= cfg_wdata;

			if (cmd.clear)
				done_q <= '0;
			else if (any_done_inc && (done_q != {DONE_W{1'b1}}))
				done_q <= done_q + 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (s_acc && (in_req == REQ_NEXT) && !all_done) begin
						state_q    <= S_SCAN;
						scan_cnt_q <= '0;
					end
				end
				S_SCAN: begin
					if (scan_cnt_q != CNT_W'(MAX_STREAMS))
						scan_cnt_q <= scan_cnt_q + 1'b1;
					else if (scan_done)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			priority if (s_acc && (in_req == REQ_NEXT) && all_done)
				m_valid_q <= 1'b1;
			else if (scan_done)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && (in_req == REQ_NEXT) && all_done) begin
			m_status_q <= ST_FINISHED;
			m_slot_q   <= '0;
			m_pos_q    <= '0;
		end else if (scan_done) begin
			if (last_tok.found) begin
				m_status_q <= ST_SELECTED;
				m_slot_q   <= OUT_SLOT_W'(last_tok.idx);
				m_pos_q    <= last_tok.key;
			end else begin
				m_status_q <= ST_EMPTY;
				m_slot_q   <= '0;
				m_pos_q    <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {4'b0, m_pos_q, m_slot_q};

endmodule
